>>> sv/rcws_pkg.sv
`default_nettype none
package rcws_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_RTT, S_DIVB, S_DIVW, S_TMO, S_LIM, S_RTX, S_SEND, S_STAT
  } back_state_e;

  typedef struct packed {
    logic        tick;
    logic [31:0] ack;
  } ev_t;

  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_RTX    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_FAST  = 2'd2;

  localparam logic [2:0] REG_MSS   = 3'd0;
  localparam logic [2:0] REG_THR   = 3'd1;
  localparam logic [2:0] REG_TOTAL = 3'd2;
  localparam logic [2:0] REG_RTT   = 3'd3;
  localparam logic [2:0] REG_DEV   = 3'd4;

  localparam logic [10:0] RST_MSS   = 11'd508;
  localparam logic [23:0] RST_THR   = 24'd64000;
  localparam logic [23:0] RST_TOTAL = 24'd0;
  localparam logic [23:0] RST_RTT   = 24'd100000;
  localparam logic [23:0] RST_DEV   = 24'd1000;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/rcws_front.sv
`default_nettype none
module rcws_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          req_type_i,
  input  wire logic [31:0]   ack_number_i,
  output logic               ev_valid_o,
  output rcws_pkg::ev_t      ev_o,
  input  wire logic          ev_pop_i
);

  rcws_pkg::ev_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign ev_valid_o = (cnt_q != 2'd0);
  assign ev_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].tick <= req_type_i;
      mem_q[wr_q].ack  <= ack_number_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (ev_pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, ev_pop_i};
    end
  end

endmodule
`default_nettype wire

>>> sv/rcws_div.sv
`default_nettype none
module rcws_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);

  logic [31:0] rem_q, quo_q, dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] shifted, trial;

  assign shifted    = {rem_q, quo_q[31]};
  assign trial      = shifted - {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/rcws_back.sv
`default_nettype none
module rcws_back #(
  parameter int MAX_BURST = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          restart_i,
  input  wire logic [10:0]   mss_cfg_i,
  input  wire logic [23:0]   thr_cfg_i,
  input  wire logic [23:0]   total_cfg_i,
  input  wire logic [23:0]   rtt_cfg_i,
  input  wire logic [23:0]   dev_cfg_i,
  input  wire logic          ev_valid_i,
  input  wire rcws_pkg::ev_t ev_i,
  output logic               ev_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         item_kind_o,
  output logic [31:0]        seq_number_o,
  output logic [31:0]        window_bytes_o,
  output logic [31:0]        threshold_bytes_o,
  output logic [1:0]         phase_o,
  output logic               finished_o,
  output logic               last_item_o
);

  localparam int CW = $clog2(MAX_BURST + 1);

  rcws_pkg::back_state_e state_q, state_d;
  rcws_pkg::ev_t ev_q;

  logic [31:0] window_q, thr_q, base_q, head_q, hi_q, elapsed_q, mean_q, dev_q;
  logic [31:0] sample_q, bm_q;
  logic [34:0] lim_q;
  logic [1:0]  phase_q, dup_q;
  logic        rtx_q;
  logic [CW-1:0] cnt_q;

  logic [10:0] mss;
  logic        fin, can_load, send_ok, rtx_due;
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q;
  logic [21:0] mss_sq;
  logic        load_rtx, load_send, load_stat;
  logic [31:0] adv, win_ss;
  logic [33:0] msum, dsum;
  logic [31:0] diff;
  logic [34:0] tmo_lim;
  logic [23:0] remain;

  assign mss      = (mss_cfg_i == 11'd0) ? 11'd1 : mss_cfg_i;
  assign mss_sq   = mss * mss;
  assign fin      = base_q >= {8'd0, total_cfg_i};
  assign can_load = !out_valid_o || !out_stall_i;
  assign send_ok  = (cnt_q < CW'(MAX_BURST)) && (head_q < window_q)
                    && ({3'd0, head_q} < lim_q);
  assign rtx_due  = rtx_q && !fin;
  assign adv      = ev_q.ack - bm_q;
  assign win_ss   = rcws_pkg::sat_add32(window_q, {21'd0, mss});
  assign msum     = {mean_q, 1'b0} + {2'd0, mean_q} + {2'd0, sample_q};
  assign diff     = (mean_q > sample_q) ? mean_q - sample_q : sample_q - mean_q;
  assign dsum     = {dev_q, 1'b0} + {2'd0, dev_q} + {2'd0, diff};
  assign tmo_lim  = {3'd0, mean_q} + {1'b0, dev_q, 2'b00};
  assign remain   = total_cfg_i - base_q[23:0];

  assign div_a = (state_q == rcws_pkg::S_RTT) ? ev_q.ack : {10'd0, mss_sq};
  assign div_b = (state_q == rcws_pkg::S_RTT) ? {21'd0, mss} : window_q;

  rcws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcws_pkg::S_IDLE:  if (!restart_i && ev_valid_i) state_d = rcws_pkg::S_CLASS;
      rcws_pkg::S_CLASS: begin
        if (!ev_q.tick && ev_q.ack > hi_q) state_d = rcws_pkg::S_RTT;
        else state_d = rcws_pkg::S_TMO;
      end
      rcws_pkg::S_RTT:   state_d = rcws_pkg::S_DIVB;
      rcws_pkg::S_DIVB: begin
        if (div_done) begin
          if (phase_q == rcws_pkg::PH_AVOID && window_q != 32'd0) state_d = rcws_pkg::S_DIVW;
          else state_d = rcws_pkg::S_TMO;
        end
      end
      rcws_pkg::S_DIVW:  if (div_done) state_d = rcws_pkg::S_TMO;
      rcws_pkg::S_TMO:   state_d = rcws_pkg::S_LIM;
      rcws_pkg::S_LIM:   state_d = rcws_pkg::S_RTX;
      rcws_pkg::S_RTX:   if (!rtx_due || can_load) state_d = rcws_pkg::S_SEND;
      rcws_pkg::S_SEND:  if (!send_ok) state_d = rcws_pkg::S_STAT;
      rcws_pkg::S_STAT:  if (can_load) state_d = rcws_pkg::S_IDLE;
      default:           state_d = rcws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ev_pop_o  = (state_q == rcws_pkg::S_IDLE) && !restart_i && ev_valid_i;
    div_start = (state_q == rcws_pkg::S_RTT) ||
                ((state_q == rcws_pkg::S_DIVB) && div_done &&
                 phase_q == rcws_pkg::PH_AVOID && window_q != 32'd0);
    load_rtx  = (state_q == rcws_pkg::S_RTX) && rtx_due && can_load;
    load_send = (state_q == rcws_pkg::S_SEND) && send_ok && can_load;
    load_stat = (state_q == rcws_pkg::S_STAT) && can_load;
  end

  // Result register: window, threshold, phase and finished are final by the time
  // any item of the event loads.
  always_ff @(posedge clk_i) begin
    if (load_rtx || load_send || load_stat) begin
      item_kind_o       <= load_rtx ? rcws_pkg::KIND_RTX :
                           load_send ? rcws_pkg::KIND_SEND : rcws_pkg::KIND_STATUS;
      seq_number_o      <= load_rtx ? bm_q : load_send ? bm_q + head_q : 32'd0;
      window_bytes_o    <= window_q;
      threshold_bytes_o <= thr_q;
      phase_o           <= phase_q;
      finished_o        <= fin;
      last_item_o       <= load_stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcws_pkg::S_IDLE;
      out_valid_o <= 1'b0;
      ev_q        <= '0;
      window_q    <= {21'd0, rcws_pkg::RST_MSS};
      thr_q       <= {8'd0, rcws_pkg::RST_THR};
      phase_q     <= rcws_pkg::PH_SLOW;
      base_q      <= '0;
      head_q      <= '0;
      hi_q        <= '0;
      dup_q       <= '0;
      elapsed_q   <= '0;
      mean_q      <= {rcws_pkg::RST_RTT, 8'd0};
      dev_q       <= {rcws_pkg::RST_DEV, 8'd0};
      sample_q    <= '0;
      bm_q        <= '0;
      lim_q       <= '0;
      rtx_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load_rtx || load_send || load_stat) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        rcws_pkg::S_IDLE: begin
          if (restart_i) begin
            window_q  <= {21'd0, mss_cfg_i};
            thr_q     <= {8'd0, thr_cfg_i};
            phase_q   <= rcws_pkg::PH_SLOW;
            base_q    <= '0;
            head_q    <= '0;
            hi_q      <= '0;
            dup_q     <= '0;
            elapsed_q <= '0;
            mean_q    <= {rtt_cfg_i, 8'd0};
            dev_q     <= {dev_cfg_i, 8'd0};
            bm_q      <= '0;
          end else if (ev_valid_i) begin
            ev_q  <= ev_i;
            rtx_q <= 1'b0;
            cnt_q <= '0;
          end
        end
        rcws_pkg::S_CLASS: begin
          if (ev_q.tick) begin
            elapsed_q <= rcws_pkg::sat_add32(elapsed_q, 32'd1);
          end else if (ev_q.ack > hi_q) begin
            hi_q     <= ev_q.ack;
            head_q   <= (head_q < adv) ? 32'd0 : head_q - adv;
            dup_q    <= '0;
            sample_q <= (elapsed_q > 32'h00FF_FFFF) ? 32'hFFFF_FF00 : {elapsed_q[23:0], 8'd0};
          end else if (ev_q.ack == hi_q) begin
            if (phase_q == rcws_pkg::PH_FAST) begin
              window_q <= win_ss;
              if (dup_q != 2'd3) dup_q <= dup_q + 2'd1;
            end else if (dup_q inside {2'd2, 2'd3}) begin
              // third duplicate: fast retransmit
              dup_q     <= '0;
              thr_q     <= {1'b0, window_q[31:1]};
              window_q  <= rcws_pkg::sat_add32({1'b0, window_q[31:1]},
                                               {19'd0, {mss, 1'b0} + {2'd0, mss}});
              phase_q   <= rcws_pkg::PH_FAST;
              rtx_q     <= 1'b1;
              elapsed_q <= '0;
            end else begin
              dup_q <= dup_q + 2'd1;
            end
          end
        end
        rcws_pkg::S_RTT: begin
          // mean first; deviation follows from the new mean
          mean_q    <= msum[33:2];
          elapsed_q <= '0;
        end
        rcws_pkg::S_DIVB: begin
          if (div_done) begin
            base_q <= div_q;
            dev_q  <= dsum[33:2];
            case (phase_q)
              rcws_pkg::PH_SLOW: begin
                window_q <= win_ss;
                if (win_ss >= thr_q) phase_q <= rcws_pkg::PH_AVOID;
              end
              rcws_pkg::PH_AVOID: if (window_q == 32'd0) window_q <= win_ss;
              default: begin
                window_q <= thr_q;
                phase_q  <= rcws_pkg::PH_AVOID;
              end
            endcase
          end
        end
        rcws_pkg::S_DIVW: if (div_done) window_q <= rcws_pkg::sat_add32(window_q, div_q);
        rcws_pkg::S_TMO: begin
          if (!fin && {elapsed_q, 8'd0} > {5'd0, tmo_lim}) begin
            thr_q     <= {1'b0, window_q[31:1]};
            window_q  <= {21'd0, mss};
            phase_q   <= rcws_pkg::PH_SLOW;
            dup_q     <= '0;
            elapsed_q <= '0;
            rtx_q     <= 1'b1;
          end
        end
        rcws_pkg::S_LIM: begin
          bm_q  <= base_q * {21'd0, mss};
          lim_q <= fin ? 35'd0 : remain * mss;
        end
        rcws_pkg::S_SEND: begin
          if (load_send) begin
            if (head_q == 32'd0) elapsed_q <= '0;
            head_q <= rcws_pkg::sat_add32(head_q, {21'd0, mss});
            cnt_q  <= cnt_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_item_o |-> item_kind_o == rcws_pkg::KIND_STATUS)
    else $error("last item is not a status item");
  a_rtx_not_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == rcws_pkg::KIND_RTX |-> !finished_o)
    else $error("retransmit after transfer finished");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == rcws_pkg::S_DIVB || state_q == rcws_pkg::S_DIVW)
    else $error("divider finished outside a divide state");

endmodule
`default_nettype wire

>>> sv/reno_congestion_window_sender_core.sv
// Work: a tick, stale or repeated ack needs no division in the back end, a new ack
//   one division and a new ack in congestion avoidance two (when the window is nonzero).
// Sends come in a burst of up to MAX_BURST, and the front queue registers each event first.
// Throughput: one event at a time in the back end; output stalls hold it there.
// Reset: asynchronous active low; registers return to their defaults and the
//   transfer state restarts from them; a write to a known register also restarts it.
`default_nettype none
module reno_congestion_window_sender_core #(
  parameter int MAX_BURST = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] ack_number_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       item_kind_o,
  output logic [31:0]      seq_number_o,
  output logic [31:0]      window_bytes_o,
  output logic [31:0]      threshold_bytes_o,
  output logic [1:0]       phase_o,
  output logic             finished_o,
  output logic             last_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  logic [10:0] mss_q;
  logic [23:0] thr_q, total_q, rtt_q, dev_q;
  logic        restart_q;
  logic        ev_valid, ev_pop;
  rcws_pkg::ev_t ev;

  // Writes must arrive only while idle (the block does not enforce it); always take the transfer.
  assign cfg_ready_o = 1'b1;

  // Hold register values; a write to a known register also sets a registered restart
  // strobe, so the transfer restarts once the new value is in place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_q     <= rcws_pkg::RST_MSS;
      thr_q     <= rcws_pkg::RST_THR;
      total_q   <= rcws_pkg::RST_TOTAL;
      rtt_q     <= rcws_pkg::RST_RTT;
      dev_q     <= rcws_pkg::RST_DEV;
      restart_q <= 1'b0;
    end else begin
      restart_q <= 1'b0;
      if (cfg_valid_i) begin
        restart_q <= 1'b1;
        case (cfg_index_i)
          rcws_pkg::REG_MSS:   mss_q   <= cfg_data_i[10:0];
          rcws_pkg::REG_THR:   thr_q   <= cfg_data_i;
          rcws_pkg::REG_TOTAL: total_q <= cfg_data_i;
          rcws_pkg::REG_RTT:   rtt_q   <= cfg_data_i;
          rcws_pkg::REG_DEV:   dev_q   <= cfg_data_i;
          default:             restart_q <= 1'b0;
        endcase
      end
    end
  end

  // Front end: queue up to two events so the input side keeps moving while the back end works; it stalls when full.
  rcws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .ack_number_i (ack_number_i),
    .ev_valid_o   (ev_valid),
    .ev_o         (ev),
    .ev_pop_i     (ev_pop)
  );

  // Back end: window update, timeout, retransmit, burst of sends, status.
  rcws_back #(
    .MAX_BURST (MAX_BURST)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .restart_i         (restart_q),
    .mss_cfg_i         (mss_q),
    .thr_cfg_i         (thr_q),
    .total_cfg_i       (total_q),
    .rtt_cfg_i         (rtt_q),
    .dev_cfg_i         (dev_q),
    .ev_valid_i        (ev_valid),
    .ev_i              (ev),
    .ev_pop_o          (ev_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .item_kind_o       (item_kind_o),
    .seq_number_o      (seq_number_o),
    .window_bytes_o    (window_bytes_o),
    .threshold_bytes_o (threshold_bytes_o),
    .phase_o           (phase_o),
    .finished_o        (finished_o),
    .last_item_o       (last_item_o)
  );

endmodule
`default_nettype wire
